// File: design/mmc3_pkg.sv
// Shared types and constants for the MMC3-style bank mapper.
package mmc3_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 10;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_COUNT   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHR_COUNT   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_SCREEN = 8'd2;

  // Bus event codes
  localparam logic [1:0] OP_CPU_WRITE = 2'd0;
  localparam logic [1:0] OP_CPU_READ  = 2'd1;
  localparam logic [1:0] OP_PPU_READ  = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  // Register decode of CPU write addresses
  localparam logic [15:0] DEC_MASK      = 16'hE001;
  localparam logic [15:0] DEC_BANK_SEL  = 16'h8000;
  localparam logic [15:0] DEC_BANK_DATA = 16'h8001;
  localparam logic [15:0] DEC_MIRROR    = 16'hA000;
  localparam logic [15:0] DEC_SRAM      = 16'hA001;
  localparam logic [15:0] DEC_IRQ_LATCH = 16'hC000;
  localparam logic [15:0] DEC_IRQ_RLD   = 16'hC001;
  localparam logic [15:0] DEC_IRQ_OFF   = 16'hE000;
  localparam logic [15:0] DEC_IRQ_ON    = 16'hE001;
  localparam logic [15:0] ADDR_EXT_PRG  = 16'h6000;
  localparam logic [15:0] ADDR_EXT_CHR  = 16'h6001;
  localparam logic [8:0]  LAST_VISIBLE  = 9'd239;

  // Bank data targets, from bank_select[2:0]
  localparam logic [2:0] BD_CHR01 = 3'd0;
  localparam logic [2:0] BD_CHR23 = 3'd1;
  localparam logic [2:0] BD_CHR4  = 3'd2;
  localparam logic [2:0] BD_CHR5  = 3'd3;
  localparam logic [2:0] BD_CHR6  = 3'd4;
  localparam logic [2:0] BD_CHR7  = 3'd5;
  localparam logic [2:0] BD_PRG_A = 3'd6;
  localparam logic [2:0] BD_PRG_B = 3'd7;

  localparam int DIV_STEPS = 9;

  typedef enum logic [2:0] {
    K_WRITE, K_PRG, K_PRG_LOW, K_CHR, K_TICK
  } kind_t;

  typedef enum logic [3:0] {
    W_NONE, W_BANK_SEL, W_BANK_DATA, W_MIRROR, W_SRAM,
    W_IRQ_LATCH, W_IRQ_RLD, W_IRQ_OFF, W_IRQ_ON, W_EXT_PRG, W_EXT_CHR
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_DIV, ST_LOAD
  } back_state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [8:0]  scanline;
    logic        rendering_on;
  } in_item_t;

  typedef struct packed {
    logic [20:0] prg_rom_addr;
    logic [18:0] chr_rom_addr;
    logic        mirror_mode;
    logic        irq_pulse;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    wr_t         wr;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        tick_ok;
  } cls_item_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

endpackage

// File: design/mmc3_front.sv
// Front end: classifies each incoming bus event for the back end.
module mmc3_front (
  input  mmc3_pkg::in_item_t  in_data,
  output mmc3_pkg::cls_item_t cls
);

  logic [15:0] dec;

  assign dec = in_data.addr & mmc3_pkg::DEC_MASK;

  // Event kind and write target
  always_comb begin
    cls.addr    = in_data.addr;
    cls.wdata   = in_data.wdata;
    cls.tick_ok = (in_data.scanline <= mmc3_pkg::LAST_VISIBLE) && in_data.rendering_on;
    cls.wr      = mmc3_pkg::W_NONE;
    cls.kind    = mmc3_pkg::K_WRITE;
    unique case (in_data.op)
      mmc3_pkg::OP_CPU_WRITE: begin
        cls.kind = mmc3_pkg::K_WRITE;
        if (in_data.addr == mmc3_pkg::ADDR_EXT_PRG) begin
          cls.wr = mmc3_pkg::W_EXT_PRG;
        end else if (in_data.addr == mmc3_pkg::ADDR_EXT_CHR) begin
          cls.wr = mmc3_pkg::W_EXT_CHR;
        end else if (in_data.addr[15]) begin
          unique case (dec)
            mmc3_pkg::DEC_BANK_SEL:  cls.wr = mmc3_pkg::W_BANK_SEL;
            mmc3_pkg::DEC_BANK_DATA: cls.wr = mmc3_pkg::W_BANK_DATA;
            mmc3_pkg::DEC_MIRROR:    cls.wr = mmc3_pkg::W_MIRROR;
            mmc3_pkg::DEC_SRAM:      cls.wr = mmc3_pkg::W_SRAM;
            mmc3_pkg::DEC_IRQ_LATCH: cls.wr = mmc3_pkg::W_IRQ_LATCH;
            mmc3_pkg::DEC_IRQ_RLD:   cls.wr = mmc3_pkg::W_IRQ_RLD;
            mmc3_pkg::DEC_IRQ_OFF:   cls.wr = mmc3_pkg::W_IRQ_OFF;
            mmc3_pkg::DEC_IRQ_ON:    cls.wr = mmc3_pkg::W_IRQ_ON;
            default:                 cls.wr = mmc3_pkg::W_NONE;
          endcase
        end
      end
      mmc3_pkg::OP_CPU_READ:
        cls.kind = in_data.addr[15] ? mmc3_pkg::K_PRG : mmc3_pkg::K_PRG_LOW;
      mmc3_pkg::OP_PPU_READ: cls.kind = mmc3_pkg::K_CHR;
      default:               cls.kind = mmc3_pkg::K_TICK;
    endcase
  end

endmodule

// File: design/mmc3_queue.sv
// Short queue of classified events between front and back end.
module mmc3_queue #(
  parameter int DEPTH = mmc3_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mmc3_pkg::cls_item_t push_data,
  input  logic                pop,
  output mmc3_pkg::cls_item_t head,
  output logic                not_empty,
  output logic                full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mmc3_pkg::cls_item_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CW'(DEPTH));
  assign head      = mem_r[rptr_r];

  // Pointer and fill count
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
    else $error("queue pop while empty");
`endif

endmodule

// File: design/mmc3_back.sv
// Back end: mapper state, bank translation with serial modulo, result register.
module mmc3_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mmc3_pkg::cfg_wr_t   cfg,
  input  mmc3_pkg::cls_item_t head,
  input  logic                q_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mmc3_pkg::out_item_t out_data
);

  mmc3_pkg::back_state_t state_r, state_nxt;

  // Configuration
  logic [8:0] prg_cnt_r;
  logic [9:0] chr_cnt_r;
  logic       four_r;

  // Mapper registers
  logic [7:0] bank_sel_r, prg_a_r, prg_b_r, ext_prg_r, irq_cnt_r, irq_rld_r;
  logic [7:0] chr_r [8];
  logic       ext_chr_r, mirror_r, irq_on_r;

  // Divider and pending translation
  logic [9:0] rem_r, den_r;
  logic [8:0] num_r;
  logic [3:0] div_cnt_r;
  logic       pend_prg_r;
  logic [12:0] off_r;
  logic [10:0] trial;
  logic [9:0]  rem_step;

  // Output register
  logic       out_valid_r;
  mmc3_pkg::out_item_t out_r;

  logic out_free, need_div, load_direct, load_div, start_div;
  logic [8:0] div_num, direct_bank, sw_bank, fixed_lo, fixed_hi;
  logic       sw;
  logic [1:0] pslot;
  logic [2:0] cslot;
  logic       mirror_nxt, pulse;
  logic [7:0] bd;
  mmc3_pkg::out_item_t direct_res;
  mmc3_pkg::out_item_t div_res;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Bank selection for the head event
  always_comb begin
    fixed_lo = prg_cnt_r - 9'd2;
    fixed_hi = prg_cnt_r - 9'd1;
    pslot    = head.addr[14:13];
    cslot    = head.addr[12:10] ^ {bank_sel_r[7], 2'b00};
    sw       = 1'b1;
    sw_bank  = '0;
    if (ext_prg_r[7]) begin
      sw_bank = {4'd0, ext_prg_r[3:0], 1'b0} + {7'd0, pslot};
    end else begin
      case (pslot)
        2'd3: begin
          sw = 1'b0;
        end
        2'd1: sw_bank = {1'b0, prg_b_r};
        2'd0: begin
          sw      = !bank_sel_r[6];
          sw_bank = {1'b0, prg_a_r};
        end
        default: begin
          sw      = bank_sel_r[6];
          sw_bank = {1'b0, prg_a_r};
        end
      endcase
    end
    if (sw) begin
      direct_bank = sw_bank;
    end else if (!ext_prg_r[7] && pslot == 2'd3) begin
      direct_bank = fixed_hi;
    end else begin
      direct_bank = fixed_lo;
    end
    need_div = 1'b0;
    div_num  = sw_bank;
    if (head.kind == mmc3_pkg::K_PRG) begin
      need_div = sw && (prg_cnt_r != '0);
    end else if (head.kind == mmc3_pkg::K_CHR) begin
      need_div = (chr_cnt_r != '0);
      div_num  = {ext_chr_r, chr_r[cslot]};
    end
  end

  // Mirroring and IRQ effect of the head event
  always_comb begin
    mirror_nxt = mirror_r;
    if (head.kind == mmc3_pkg::K_WRITE && head.wr == mmc3_pkg::W_MIRROR && !four_r) begin
      mirror_nxt = !head.wdata[0];
    end
    pulse = (head.kind == mmc3_pkg::K_TICK) && head.tick_ok && irq_on_r && (irq_cnt_r == '0);
  end

  // Result of an event that needs no reduction
  always_comb begin
    direct_res              = '0;
    direct_res.mirror_mode  = mirror_nxt;
    direct_res.irq_pulse    = pulse;
    if (head.kind == mmc3_pkg::K_PRG) begin
      direct_res.prg_rom_addr = {direct_bank[7:0], head.addr[12:0]};
    end else if (head.kind == mmc3_pkg::K_CHR) begin
      direct_res.chr_rom_addr = {3'd0, head.addr};
    end
  end

  // Result of a reduced translation
  always_comb begin
    div_res             = '0;
    div_res.mirror_mode = mirror_r;
    if (pend_prg_r) begin
      div_res.prg_rom_addr = {rem_r[7:0], off_r};
    end else begin
      div_res.chr_rom_addr = {rem_r[8:0], off_r[9:0]};
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mmc3_pkg::ST_IDLE:
        if (q_valid && out_free && need_div) begin
          state_nxt = mmc3_pkg::ST_DIV;
        end
      mmc3_pkg::ST_DIV:
        if (div_cnt_r == 4'd1) begin
          state_nxt = mmc3_pkg::ST_LOAD;
        end
      mmc3_pkg::ST_LOAD:
        if (out_free) begin
          state_nxt = mmc3_pkg::ST_IDLE;
        end
      default: state_nxt = mmc3_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop         = 1'b0;
    load_direct = 1'b0;
    load_div    = 1'b0;
    start_div   = 1'b0;
    unique case (state_r)
      mmc3_pkg::ST_IDLE: begin
        pop         = q_valid && out_free;
        load_direct = pop && !need_div;
        start_div   = pop && need_div;
      end
      mmc3_pkg::ST_LOAD: load_div = out_free;
      default: ;
    endcase
  end

  // One restoring remainder step per cycle
  assign trial    = {rem_r, num_r[8]};
  assign rem_step = (trial >= {1'b0, den_r}) ? 10'(trial - {1'b0, den_r}) : trial[9:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mmc3_pkg::ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (start_div) begin
        div_cnt_r <= 4'(mmc3_pkg::DIV_STEPS);
      end else if (state_r == mmc3_pkg::ST_DIV) begin
        div_cnt_r <= div_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      rem_r      <= '0;
      num_r      <= div_num;
      den_r      <= (head.kind == mmc3_pkg::K_PRG) ? {1'b0, prg_cnt_r} : chr_cnt_r;
      pend_prg_r <= (head.kind == mmc3_pkg::K_PRG);
      off_r      <= head.addr[12:0];
    end else if (state_r == mmc3_pkg::ST_DIV) begin
      rem_r <= rem_step;
      num_r <= {num_r[7:0], 1'b0};
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_cnt_r <= 9'd32;
      chr_cnt_r <= 10'd256;
      four_r    <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        mmc3_pkg::CFG_PRG_COUNT:   prg_cnt_r <= cfg.data[8:0];
        mmc3_pkg::CFG_CHR_COUNT:   chr_cnt_r <= cfg.data;
        mmc3_pkg::CFG_FOUR_SCREEN: four_r    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Mapper register writes and IRQ counter
  assign bd = head.wdata & 8'hFE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_sel_r <= '0;
      prg_a_r    <= 8'd0;
      prg_b_r    <= 8'd1;
      ext_prg_r  <= '0;
      ext_chr_r  <= 1'b0;
      mirror_r   <= 1'b0;
      irq_cnt_r  <= '0;
      irq_rld_r  <= '0;
      irq_on_r   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chr_r[i] <= 8'(i);
      end
    end else if (pop) begin
      mirror_r <= mirror_nxt;
      if (head.kind == mmc3_pkg::K_WRITE) begin
        unique case (head.wr)
          mmc3_pkg::W_BANK_SEL:  bank_sel_r <= head.wdata;
          mmc3_pkg::W_BANK_DATA: begin
            unique case (bank_sel_r[2:0])
              mmc3_pkg::BD_CHR01: begin
                chr_r[0] <= bd;
                chr_r[1] <= bd + 8'd1;
              end
              mmc3_pkg::BD_CHR23: begin
                chr_r[2] <= bd;
                chr_r[3] <= bd + 8'd1;
              end
              mmc3_pkg::BD_CHR4:  chr_r[4] <= head.wdata;
              mmc3_pkg::BD_CHR5:  chr_r[5] <= head.wdata;
              mmc3_pkg::BD_CHR6:  chr_r[6] <= head.wdata;
              mmc3_pkg::BD_CHR7:  chr_r[7] <= head.wdata;
              mmc3_pkg::BD_PRG_A: prg_a_r  <= head.wdata;
              default:            prg_b_r  <= head.wdata;
            endcase
          end
          mmc3_pkg::W_IRQ_LATCH: begin
            irq_cnt_r <= head.wdata;
            irq_on_r  <= 1'b1;
          end
          mmc3_pkg::W_IRQ_RLD: irq_rld_r <= head.wdata;
          mmc3_pkg::W_IRQ_OFF: irq_on_r  <= 1'b0;
          mmc3_pkg::W_IRQ_ON:  irq_on_r  <= 1'b1;
          mmc3_pkg::W_EXT_PRG: ext_prg_r <= head.wdata;
          mmc3_pkg::W_EXT_CHR: ext_chr_r <= head.wdata[0];
          default: ;
        endcase
      end else if (head.kind == mmc3_pkg::K_TICK && head.tick_ok && irq_on_r) begin
        irq_cnt_r <= (irq_cnt_r == '0) ? irq_rld_r : irq_cnt_r - 8'd1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_direct || load_div) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      out_r <= direct_res;
    end else if (load_div) begin
      out_r <= div_res;
    end
  end

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result overwritten");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmc3_pkg::ST_DIV) |-> (div_cnt_r != '0))
    else $error("divider running with zero step count");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mmc3_pkg::ST_IDLE) |-> !pop)
    else $error("event taken while a translation is pending");
`endif

endmodule

// File: design/mmc3_clone_bank_mapper_irq.sv
// Top level of the MMC3-style bank mapper with extension registers and IRQ counter.
// Path: writes, ticks and unreduced translations pass the queue and then the result register;
// a translation reduced by the bank count also passes the 9-step serial remainder unit.
// Throughput: one item per cycle for writes and ticks while the output is not stalled; the
// back end takes no new item while the serial remainder unit works on a reduced translation.
// Reset (rst_n low, synchronous) empties the queue and result register and restores
// all mapper and configuration registers to their power-on values.
module mmc3_clone_bank_mapper_irq #(
  parameter int QUEUE_DEPTH = mmc3_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mmc3_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mmc3_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmc3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mmc3_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mmc3_pkg::cls_item_t cls, head;
  mmc3_pkg::cfg_wr_t   cfg;
  logic q_full, q_valid, pop, push;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  mmc3_front u_front (
    .in_data (in_data),
    .cls     (cls)
  );

  mmc3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  mmc3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head      (head),
    .q_valid   (q_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/mmc3_clone_bank_mapper_irq_tb.sv
// Self-checking testbench for the MMC3-style bank mapper: directed and random bus events checked by a predictor.
`timescale 1ns / 100ps

module mmc3_clone_bank_mapper_irq_tb;
  import mmc3_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mmc3_clone_bank_mapper_irq uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [8:0] m_prg_cnt;
  logic [9:0] m_chr_cnt;
  logic       m_four;
  logic [7:0] m_bsel, m_prg_a, m_prg_b, m_ext_prg;
  logic [7:0] m_chr [8];
  logic       m_ext_chr, m_mirror, m_irq_on;
  logic [7:0] m_irq_cnt, m_irq_rld;

  in_item_t  pending_beats[$];
  out_item_t expected_beats[$];
  int        send_idle_pct = 23;
  int        recv_idle_pct = 49;
  int        errors = 0;
  bit        stim_done = 0;

  task automatic mapper_reset();
    m_prg_cnt = 9'd32; m_chr_cnt = 10'd256; m_four = 1'b0;
    m_bsel = '0; m_prg_a = '0; m_prg_b = 8'd1; m_ext_prg = '0;
    for (int i = 0; i < 8; i++) m_chr[i] = 8'(i);
    m_ext_chr = 1'b0; m_mirror = 1'b0; m_irq_on = 1'b0;
    m_irq_cnt = '0; m_irq_rld = '0;
  endtask

  function automatic logic [8:0] reduce_prg(input logic [8:0] bank);
    if (m_prg_cnt == 0) return bank;
    return bank % m_prg_cnt;
  endfunction

  function automatic logic [8:0] prg_bank_for(input logic [1:0] slot);
    logic [8:0] fix_lo, fix_hi;
    fix_lo = m_prg_cnt - 9'd2;
    fix_hi = m_prg_cnt - 9'd1;
    if (m_ext_prg[7]) return reduce_prg({4'd0, m_ext_prg[3:0], 1'b0} + {7'd0, slot});
    if (slot == 2'd3) return fix_hi;
    if (slot == 2'd1) return reduce_prg({1'b0, m_prg_b});
    if (m_bsel[6]) return (slot == 2'd0) ? fix_lo : reduce_prg({1'b0, m_prg_a});
    return (slot == 2'd0) ? reduce_prg({1'b0, m_prg_a}) : fix_lo;
  endfunction

  // Apply one bus event and return the mapped result
  function automatic out_item_t map_event(input in_item_t it);
    out_item_t r;
    logic [2:0] slot;
    logic [9:0] cbank;
    r = '0;
    case (it.op)
      OP_CPU_WRITE: begin
        if (it.addr == ADDR_EXT_PRG) m_ext_prg = it.wdata;
        else if (it.addr == ADDR_EXT_CHR) m_ext_chr = it.wdata[0];
        else if (it.addr[15]) begin
          case (it.addr & DEC_MASK)
            DEC_BANK_SEL: m_bsel = it.wdata;
            DEC_BANK_DATA: begin
              case (m_bsel[2:0])
                BD_CHR01: begin m_chr[0] = it.wdata & 8'hFE; m_chr[1] = m_chr[0] + 8'd1; end
                BD_CHR23: begin m_chr[2] = it.wdata & 8'hFE; m_chr[3] = m_chr[2] + 8'd1; end
                BD_CHR4: m_chr[4] = it.wdata;
                BD_CHR5: m_chr[5] = it.wdata;
                BD_CHR6: m_chr[6] = it.wdata;
                BD_CHR7: m_chr[7] = it.wdata;
                BD_PRG_A: m_prg_a = it.wdata;
                default: m_prg_b = it.wdata;
              endcase
            end
            DEC_MIRROR: if (!m_four) m_mirror = ~it.wdata[0];
            DEC_IRQ_LATCH: begin m_irq_cnt = it.wdata; m_irq_on = 1'b1; end
            DEC_IRQ_RLD: m_irq_rld = it.wdata;
            DEC_IRQ_OFF: m_irq_on = 1'b0;
            DEC_IRQ_ON: m_irq_on = 1'b1;
            default: ;
          endcase
        end
      end
      OP_CPU_READ: begin
        if (it.addr[15]) r.prg_rom_addr = 21'({prg_bank_for(it.addr[14:13]), it.addr[12:0]});
      end
      OP_PPU_READ: begin
        if (m_chr_cnt == 0) r.chr_rom_addr = 19'(it.addr);
        else begin
          slot = it.addr[12:10] ^ {m_bsel[7], 2'b00};
          cbank = ({1'b0, m_ext_chr, m_chr[slot]}) % m_chr_cnt;
          r.chr_rom_addr = 19'({cbank, it.addr[9:0]});
        end
      end
      default: begin
        if (it.scanline <= LAST_VISIBLE && it.rendering_on && m_irq_on) begin
          if (m_irq_cnt == 0) begin m_irq_cnt = m_irq_rld; r.irq_pulse = 1'b1; end
          else m_irq_cnt = m_irq_cnt - 8'd1;
        end
      end
    endcase
    r.mirror_mode = m_mirror;
    return r;
  endfunction

  // Driver: present queued beats, random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Predict on accept
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) expected_beats.push_back(map_event(in_data));
  end

  // Monitor: compare each result beat
  always @(posedge clk) begin
    out_item_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat %h", out_data);
        errors++;
      end else begin
        exp_b = expected_beats.pop_front();
        if (out_data.prg_rom_addr !== exp_b.prg_rom_addr) begin
          $error("prg_rom_addr exp %h got %h", exp_b.prg_rom_addr, out_data.prg_rom_addr);
          errors++;
        end
        if (out_data.chr_rom_addr !== exp_b.chr_rom_addr) begin
          $error("chr_rom_addr exp %h got %h", exp_b.chr_rom_addr, out_data.chr_rom_addr);
          errors++;
        end
        if (out_data.mirror_mode !== exp_b.mirror_mode) begin
          $error("mirror_mode exp %b got %b", exp_b.mirror_mode, out_data.mirror_mode);
          errors++;
        end
        if (out_data.irq_pulse !== exp_b.irq_pulse) begin
          $error("irq_pulse exp %b got %b", exp_b.irq_pulse, out_data.irq_pulse);
          errors++;
        end
      end
    end
  end

  function automatic in_item_t mk(input logic [1:0] op, input logic [15:0] a,
                                  input logic [7:0] d);
    in_item_t it;
    it.op = op; it.addr = a; it.wdata = d;
    it.scanline = 9'($urandom_range(261)); it.rendering_on = 1'($urandom);
    return it;
  endfunction

  // Random event: mostly register writes and translations with random content
  function automatic in_item_t rand_event();
    in_item_t it;
    int k;
    logic [15:0] regs [8];
    regs = '{DEC_BANK_SEL, DEC_BANK_DATA, DEC_MIRROR, DEC_SRAM,
             DEC_IRQ_LATCH, DEC_IRQ_RLD, DEC_IRQ_OFF, DEC_IRQ_ON};
    k = $urandom_range(99);
    it = mk(OP_CPU_WRITE, 16'($urandom), 8'($urandom));
    if (k < 25) it.addr = regs[$urandom_range(7)] | (16'($urandom) & 16'h1FFE);
    else if (k < 32) it.addr = $urandom_range(1) ? ADDR_EXT_PRG : ADDR_EXT_CHR;
    else if (k < 36) it.addr = 16'($urandom);
    else if (k < 56) it.op = OP_CPU_READ;
    else if (k < 74) begin
      it.op = OP_PPU_READ;
      if ($urandom_range(9)) it.addr[15:13] = 3'd0;
    end
    else begin
      it.op = OP_TICK;
      if ($urandom_range(4)) begin
        it.scanline = 9'($urandom_range(239));
        it.rendering_on = 1'b1;
      end
    end
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_index <= idx; cfg_data <= v; cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_PRG_COUNT) m_prg_cnt = v[8:0];
    else if (idx == CFG_CHR_COUNT) m_chr_cnt = v;
    else if (idx == CFG_FOUR_SCREEN) m_four = v[0];
  endtask

  initial begin
    int prg_set [5] = '{2, 256, 32, 5, 17};
    int chr_set [5] = '{512, 0, 256, 3, 100};
    mapper_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, each register, special cases
    pending_beats.push_back(mk(OP_CPU_READ, 16'h0000, 8'h00));
    pending_beats.push_back(mk(OP_CPU_READ, 16'hFFFF, 8'h00));
    pending_beats.push_back(mk(OP_CPU_WRITE, 16'h1234, 8'hFF));
    pending_beats.push_back(mk(OP_CPU_WRITE, DEC_BANK_SEL, 8'hC6));
    pending_beats.push_back(mk(OP_CPU_WRITE, DEC_BANK_DATA, 8'hFF));
    pending_beats.push_back(mk(OP_CPU_READ, 16'h8000, 8'h00));
    pending_beats.push_back(mk(OP_PPU_READ, 16'h1FFF, 8'h00));
    pending_beats.push_back(mk(OP_CPU_WRITE, DEC_MIRROR, 8'h01));
    pending_beats.push_back(mk(OP_CPU_WRITE, DEC_SRAM, 8'h80));
    pending_beats.push_back(mk(OP_CPU_WRITE, ADDR_EXT_PRG, 8'hFF));
    pending_beats.push_back(mk(OP_CPU_READ, 16'hE123, 8'h00));
    pending_beats.push_back(mk(OP_CPU_WRITE, ADDR_EXT_CHR, 8'hFF));
    pending_beats.push_back(mk(OP_PPU_READ, 16'hFFFF, 8'h00));
    pending_beats.push_back(mk(OP_CPU_WRITE, DEC_IRQ_RLD, 8'h01));
    pending_beats.push_back(mk(OP_CPU_WRITE, DEC_IRQ_LATCH, 8'h00));
    for (int i = 0; i < 4; i++) begin
      in_item_t t;
      t = mk(OP_TICK, 16'h0000, 8'h00);
      t.scanline = (i == 3) ? 9'd240 : 9'd239;
      t.rendering_on = 1'b1;
      pending_beats.push_back(t);
    end
    pending_beats.push_back(mk(OP_CPU_WRITE, DEC_IRQ_OFF, 8'h00));
    pending_beats.push_back(mk(OP_CPU_WRITE, DEC_IRQ_ON, 8'h00));
    pending_beats.push_back(mk(OP_CPU_WRITE, ADDR_EXT_PRG, 8'h00));
    wait_idle();
    // Random phases over configuration settings and idling patterns
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(CFG_PRG_COUNT, 10'(prg_set[ph]));
      cfg_write(CFG_CHR_COUNT, 10'(chr_set[ph]));
      cfg_write(CFG_FOUR_SCREEN, 10'(ph % 2));
      if (ph == 4) cfg_write(8'd7, 10'h3FF);
      send_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 49 : 0;
      recv_idle_pct = (ph < 2) ? 49 : (ph < 4) ? 23 : 0;
      for (int n = 0; n < 165; n++) pending_beats.push_back(rand_event());
      wait_idle();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
design/mmc3_pkg.sv
design/mmc3_front.sv
design/mmc3_queue.sv
design/mmc3_back.sv
design/mmc3_clone_bank_mapper_irq.sv
tb/mmc3_clone_bank_mapper_irq_tb.sv
